/* rtl/core/srsw_pkg.sv */
package srsw_pkg;

  // Send window (sends per round), effective value capped at sixteen
  localparam int WINDOW = 16;
  localparam int WIN_EFF = (WINDOW > 16) ? 16 : WINDOW;
  localparam logic [4:0] WIN_CNT = 5'(WIN_EFF);

  // Bitmap row geometry: sixteen ack bits per memory word
  localparam int ROW_W = 16;
  localparam int ROW_BW = 4;

  // Field widths
  localparam int SEQ_W = 16;
  localparam int CNT_W = 17;
  localparam int TMR_W = 20;

  // Round timer bounds in microseconds
  localparam logic [TMR_W-1:0] TIMER_CEIL = 20'd760000;
  localparam logic [TMR_W-1:0] TIMER_RESET = 20'd650000;

  // Consecutive timeouts that end the transfer
  localparam logic [1:0] ABORT_MISSES = 2'd3;

  // Reciprocal constants for the divide-by-constant steps
  localparam logic [21:0] RECIP_5 = 22'd3355443;    // floor(2^24 / 5)
  localparam logic [21:0] RECIP_100 = 22'd2684354;  // floor(2^28 / 100)

  typedef enum logic [1:0] {
    ACT_START = 2'd0,
    ACT_ACK   = 2'd1,
    ACT_TMO   = 2'd2,
    ACT_CLOSE = 2'd3
  } action_e;

  typedef enum logic [2:0] {
    KIND_SEND   = 3'd0,
    KIND_DONE   = 3'd1,
    KIND_ABORT  = 3'd2,
    KIND_ACK    = 3'd3,
    KIND_BAD    = 3'd4,
    KIND_CLOSED = 3'd5
  } kind_e;

  // Request into the round timer update unit
  typedef struct packed {
    logic             start;
    logic [TMR_W-1:0] timer;
    logic [4:0]       sent;
    logic [4:0]       acks;
  } tmr_req_t;

  // Answer from the round timer update unit
  typedef struct packed {
    logic             done;
    logic [TMR_W-1:0] timer;
  } tmr_rsp_t;

endpackage

/* rtl/core/srsw_bitmap.sv */
module srsw_bitmap #(
  parameter int ROWS = 4096,
  parameter int AW = 12
) (
  input  logic                     clk_i,
  input  logic                     re_i,
  input  logic [AW-1:0]            raddr_i,
  output logic [srsw_pkg::ROW_W-1:0] rdata_o,
  input  logic                     we_i,
  input  logic [AW-1:0]            waddr_i,
  input  logic [srsw_pkg::ROW_W-1:0] wdata_i
);
  import srsw_pkg::*;

  logic [ROW_W-1:0] mem [ROWS];
  logic [ROW_W-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/core/srsw_timer.sv */
module srsw_timer (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  srsw_pkg::tmr_req_t req_i,
  output srsw_pkg::tmr_rsp_t rsp_o
);
  import srsw_pkg::*;

  // Step 1: gap*3 times 1/5; step 2: correct and grow;
  // step 3: timer times 1/100; step 4: correct and shrink.
  logic [2:0]       step_q;
  logic             grow_q, shrink_q;
  logic [TMR_W-1:0] t0_q, t1_q, q5, q100;
  logic [21:0]      x_q, r5;
  logic [43:0]      p5_q;
  logic [41:0]      p100_q;
  logic [TMR_W-1:0] r100;
  logic [TMR_W-1:0] gap;
  logic [5:0]       three_s;
  logic [TMR_W-1:0] t1_d, t2;
  logic [TMR_W-1:0] q5_c, q100_c;

  assign gap = (req_i.timer < TIMER_CEIL) ? (TIMER_CEIL - req_i.timer) : '0;
  assign three_s = 6'({1'b0, req_i.sent} + {req_i.sent, 1'b0});

  // Quotient estimates are low by at most one
  assign q5 = p5_q[43:24];
  assign r5 = x_q - ({q5, 2'b00} + {2'b00, q5});
  assign q5_c = (r5 >= 22'd5) ? q5 + 1'b1 : q5;
  assign t1_d = grow_q ? t0_q + q5_c : t0_q;

  assign q100 = p100_q[41:28] == '0 ? '0 : TMR_W'(p100_q[41:28]);
  assign r100 = t1_q - TMR_W'(q100 * 7'd100);
  assign q100_c = (r100 >= 20'd100) ? q100 + 1'b1 : q100;
  assign t2 = shrink_q ? t1_q - q100_c : t1_q;

  // Step counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
    end else if (req_i.start) begin
      step_q <= 3'd1;
    end else if (step_q == 3'd4) begin
      step_q <= '0;
    end else if (step_q != '0) begin
      step_q <= step_q + 1'b1;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      t0_q     <= req_i.timer;
      x_q      <= 22'({2'b00, gap} + {1'b0, gap, 1'b0});
      grow_q   <= (6'(req_i.acks) < (three_s >> 2)) && (req_i.sent == WIN_CNT);
      shrink_q <= (6'(req_i.acks) + 6'd2) > 6'(req_i.sent);
    end
    if (step_q == 3'd1) begin
      p5_q <= x_q * RECIP_5;
    end
    if (step_q == 3'd2) begin
      t1_q <= t1_d;
    end
    if (step_q == 3'd3) begin
      p100_q <= t1_q * RECIP_100;
    end
  end

  assign rsp_o.done  = (step_q == 3'd4);
  assign rsp_o.timer = t2;

endmodule

/* rtl/core/selective_repeat_sender_window_core.sv */
// Answers: an ack passes the ack-write and emit states, a bad ack or abort goes straight
//   to emit; a round close waits in ST_TMR on the four-step timer update unit.
// Start round: each 16-entry bitmap row scanned is read, masked and searched, with
//   one send at a time; one item is processed at a time, as s_axis_tready is high
//   only while idle.
// Reset: all control state clears, then a clearing pass writes MAX_PACKETS/16
//   bitmap rows (4096 at default) before the first input is accepted.
module selective_repeat_sender_window_core #(
  parameter int MAX_PACKETS = 65536
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration
  input  logic        cfg_we_i,
  input  logic [16:0] cfg_wdata_i,   // packet_count
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,  // [15:0] ack_seq
  input  logic [1:0]  s_axis_tuser,  // [1:0] action
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,  // [15:0] seq, [35:16] timer_us, [39:36] zero
  output logic [2:0]  m_axis_tuser,  // [2:0] kind
  output logic        m_axis_tlast
);
  import srsw_pkg::*;

  localparam int ROWS = (MAX_PACKETS + ROW_W - 1) / ROW_W;
  localparam int RAW = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam logic [CNT_W-1:0] MaxPk = CNT_W'(MAX_PACKETS);
  localparam logic [RAW-1:0] LastRow = RAW'(ROWS - 1);

  // Sequencer states
  localparam logic [3:0] ST_CLEAR = 4'd0;
  localparam logic [3:0] ST_IDLE  = 4'd1;
  localparam logic [3:0] ST_ACKWR = 4'd2;
  localparam logic [3:0] ST_SCRD  = 4'd3;
  localparam logic [3:0] ST_SCLD  = 4'd4;
  localparam logic [3:0] ST_FIND  = 4'd5;
  localparam logic [3:0] ST_SCEND = 4'd6;
  localparam logic [3:0] ST_TMR   = 4'd7;
  localparam logic [3:0] ST_EMIT  = 4'd8;

  logic [3:0]       state_q, state_d;
  logic [RAW-1:0]   clr_q, clr_d;
  logic [CNT_W-1:0] pkt_q;
  logic [SEQ_W-1:0] scan_q, scan_d;
  logic [4:0]       sent_q, sent_d;
  logic [4:0]       acks_q, acks_d;
  logic [1:0]       miss_q, miss_d;
  logic [TMR_W-1:0] timer_q, timer_d;

  // Scan working state
  logic [CNT_W-1:0] cur_q, cur_d;
  logic [ROW_W-1:0] mask_q, mask_d;
  logic [4:0]       n_q, n_d;
  logic             pend_vld_q, pend_vld_d;
  logic [SEQ_W-1:0] pend_q, pend_d;
  logic [SEQ_W-1:0] first_q, first_d;

  // Held item and pending single result
  logic [SEQ_W-1:0] seq_q, seq_d;
  kind_e            res_kind_q, res_kind_d;
  logic [SEQ_W-1:0] res_seq_q, res_seq_d;

  // Output register
  logic             out_vld_q, out_vld_d;
  kind_e            out_kind_q;
  logic [SEQ_W-1:0] out_seq_q;
  logic [TMR_W-1:0] out_tmr_q;
  logic             out_last_q;
  logic             out_ld;
  kind_e            out_kind_d;
  logic [SEQ_W-1:0] out_seq_d;
  logic [TMR_W-1:0] out_tmr_d;
  logic             out_last_d;
  logic             out_free;

  // Memory ports
  logic             mem_re, mem_we;
  logic [RAW-1:0]   mem_raddr, mem_waddr;
  logic [ROW_W-1:0] mem_rdata, mem_wdata;

  tmr_req_t         tmr_req;
  tmr_rsp_t         tmr_rsp;

  logic             in_xfer;
  action_e          act;
  logic [SEQ_W-1:0] in_seq;
  logic             aborted;
  logic [ROW_W-1:0] row_mask;
  logic [ROW_BW-1:0] ffs;
  logic [CNT_W-1:0] next_row;

  assign in_xfer = s_axis_tvalid && s_axis_tready;
  assign act = action_e'(s_axis_tuser);
  assign in_seq = s_axis_tdata;
  assign aborted = (miss_q == ABORT_MISSES);
  assign out_free = !out_vld_q || m_axis_tready;
  assign s_axis_tready = (state_q == ST_IDLE);

  // Unacked, in-window bits of the freshly read row
  always_comb begin
    for (int b = 0; b < ROW_W; b++) begin
      row_mask[b] = !mem_rdata[b] && (ROW_BW'(b) >= cur_q[ROW_BW-1:0]) &&
                    ({cur_q[CNT_W-1:ROW_BW], ROW_BW'(b)} < pkt_q);
    end
  end

  // Lowest remaining candidate in the working mask
  always_comb begin
    ffs = '0;
    for (int b = ROW_W - 1; b >= 0; b--) begin
      if (mask_q[b]) begin
        ffs = ROW_BW'(b);
      end
    end
  end

  assign next_row = {cur_q[CNT_W-1:ROW_BW] + 1'b1, {ROW_BW{1'b0}}};

  // Sequencer
  always_comb begin
    state_d    = state_q;
    clr_d      = clr_q;
    scan_d     = scan_q;
    sent_d     = sent_q;
    acks_d     = acks_q;
    miss_d     = miss_q;
    timer_d    = timer_q;
    cur_d      = cur_q;
    mask_d     = mask_q;
    n_d        = n_q;
    pend_vld_d = pend_vld_q;
    pend_d     = pend_q;
    first_d    = first_q;
    seq_d      = seq_q;
    res_kind_d = res_kind_q;
    res_seq_d  = res_seq_q;
    out_ld     = 1'b0;
    out_kind_d = KIND_SEND;
    out_seq_d  = '0;
    out_tmr_d  = timer_q;
    out_last_d = 1'b1;
    mem_re     = 1'b0;
    mem_raddr  = RAW'(cur_q >> ROW_BW);
    mem_we     = 1'b0;
    mem_waddr  = RAW'(seq_q >> ROW_BW);
    mem_wdata  = mem_rdata | (ROW_W'(1) << seq_q[ROW_BW-1:0]);
    tmr_req.start = 1'b0;
    tmr_req.timer = timer_q;
    tmr_req.sent  = sent_q;
    tmr_req.acks  = acks_q;

    case (state_q)
      // Zero the bitmap after reset, one row a cycle
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        mem_wdata = '0;
        clr_d     = clr_q + 1'b1;
        if (clr_q == LastRow) begin
          state_d = ST_IDLE;
        end
      end

      // Decode the accepted item
      ST_IDLE: begin
        if (in_xfer) begin
          seq_d      = in_seq;
          res_seq_d  = '0;
          res_kind_d = KIND_ABORT;
          if (aborted) begin
            state_d = ST_EMIT;
          end else begin
            case (act)
              ACT_START: begin
                acks_d = '0;
                if ({1'b0, scan_q} >= pkt_q) begin
                  res_kind_d = KIND_DONE;
                  state_d    = ST_EMIT;
                end else begin
                  cur_d      = {1'b0, scan_q};
                  n_d        = '0;
                  pend_vld_d = 1'b0;
                  state_d    = ST_SCRD;
                end
              end
              ACT_ACK: begin
                if ({1'b0, in_seq} >= pkt_q) begin
                  res_kind_d = KIND_BAD;
                  res_seq_d  = in_seq;
                  state_d    = ST_EMIT;
                end else begin
                  mem_re    = 1'b1;
                  mem_raddr = RAW'(in_seq >> ROW_BW);
                  state_d   = ST_ACKWR;
                end
              end
              ACT_TMO: begin
                if (miss_q == ABORT_MISSES - 2'd1) begin
                  miss_d  = ABORT_MISSES;
                  state_d = ST_EMIT;
                end else begin
                  miss_d        = miss_q + 1'b1;
                  tmr_req.start = 1'b1;
                  state_d       = ST_TMR;
                end
              end
              ACT_CLOSE: begin
                tmr_req.start = 1'b1;
                state_d       = ST_TMR;
              end
              default: begin
                state_d = ST_IDLE;
              end
            endcase
          end
        end
      end

      // Read data is back: set the ack bit
      ST_ACKWR: begin
        mem_we     = 1'b1;
        acks_d     = (acks_q == 5'd31) ? acks_q : acks_q + 1'b1;
        miss_d     = '0;
        res_kind_d = KIND_ACK;
        res_seq_d  = seq_q;
        state_d    = ST_EMIT;
      end

      ST_SCRD: begin
        mem_re  = 1'b1;
        state_d = ST_SCLD;
      end

      ST_SCLD: begin
        mask_d  = row_mask;
        state_d = ST_FIND;
      end

      // Take candidates one a cycle while the output register is free; hold one back to know which is last
      ST_FIND: begin
        if (mask_q == '0) begin
          if (next_row >= pkt_q) begin
            state_d = ST_SCEND;
          end else begin
            cur_d   = next_row;
            state_d = ST_SCRD;
          end
        end else if (!pend_vld_q || out_free) begin
          mask_d[ffs] = 1'b0;
          pend_d      = {cur_q[SEQ_W-1:ROW_BW], ffs};
          pend_vld_d  = 1'b1;
          n_d         = n_q + 1'b1;
          if (n_q == '0) begin
            first_d = {cur_q[SEQ_W-1:ROW_BW], ffs};
          end
          if (pend_vld_q) begin
            out_ld     = 1'b1;
            out_kind_d = KIND_SEND;
            out_seq_d  = pend_q;
            out_last_d = 1'b0;
          end
          if (n_q + 1'b1 == WIN_CNT) begin
            state_d = ST_SCEND;
          end
        end
      end

      // Final send, or done when nothing was found
      ST_SCEND: begin
        if (out_free) begin
          out_ld  = 1'b1;
          state_d = ST_IDLE;
          if (pend_vld_q) begin
            out_kind_d = KIND_SEND;
            out_seq_d  = pend_q;
            scan_d     = first_q;
            sent_d     = n_q;
          end else begin
            out_kind_d = KIND_DONE;
          end
        end
      end

      ST_TMR: begin
        if (tmr_rsp.done) begin
          timer_d    = tmr_rsp.timer;
          sent_d     = '0;
          acks_d     = '0;
          res_kind_d = KIND_CLOSED;
          state_d    = ST_EMIT;
        end
      end

      ST_EMIT: begin
        if (out_free) begin
          out_ld     = 1'b1;
          out_kind_d = res_kind_q;
          out_seq_d  = res_seq_q;
          state_d    = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_CLEAR;
      clr_q      <= '0;
      pkt_q      <= CNT_W'(1);
      scan_q     <= '0;
      sent_q     <= '0;
      acks_q     <= '0;
      miss_q     <= '0;
      timer_q    <= TIMER_RESET;
      pend_vld_q <= 1'b0;
      n_q        <= '0;
      out_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      clr_q      <= clr_d;
      scan_q     <= scan_d;
      sent_q     <= sent_d;
      acks_q     <= acks_d;
      miss_q     <= miss_d;
      timer_q    <= timer_d;
      pend_vld_q <= pend_vld_d;
      n_q        <= n_d;
      out_vld_q  <= out_vld_d;
      if (cfg_we_i) begin
        pkt_q <= (cfg_wdata_i > MaxPk) ? MaxPk : cfg_wdata_i;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    cur_q      <= cur_d;
    mask_q     <= mask_d;
    pend_q     <= pend_d;
    first_q    <= first_d;
    seq_q      <= seq_d;
    res_kind_q <= res_kind_d;
    res_seq_q  <= res_seq_d;
    if (out_ld) begin
      out_kind_q <= out_kind_d;
      out_seq_q  <= out_seq_d;
      out_tmr_q  <= out_tmr_d;
      out_last_q <= out_last_d;
    end
  end

  assign out_vld_d = out_ld || (out_vld_q && !m_axis_tready);

  srsw_bitmap #(
    .ROWS(ROWS),
    .AW  (RAW)
  ) u_bitmap (
    .clk_i  (clk_i),
    .re_i   (mem_re),
    .raddr_i(mem_raddr),
    .rdata_o(mem_rdata),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata)
  );

  srsw_timer u_timer (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (tmr_req),
    .rsp_o (tmr_rsp)
  );

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tuser  = out_kind_q;
  assign m_axis_tdata  = {4'b0000, out_tmr_q, out_seq_q};
  assign m_axis_tlast  = out_last_q;

  // Once aborted, the transfer stays aborted until reset
  a_abort_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    aborted |=> aborted)
    else $error("abort state left without reset");

  // The timer unit only answers while the sequencer waits for it
  a_tmr_done_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tmr_rsp.done |-> (state_q == ST_TMR))
    else $error("timer update finished outside of round close");

  // A finished round records between one and a full window of sends
  a_round_sent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCEND && pend_vld_q && out_free) |=>
      (sent_q != '0 && sent_q <= WIN_CNT))
    else $error("round send count out of range");

  // Round timer never grows past its ceiling
  a_timer_ceil: assert property (@(posedge clk_i) disable iff (!rst_ni)
    timer_q <= TIMER_CEIL)
    else $error("round timer above ceiling");

endmodule

/* tb/sv/selective_repeat_sender_window_core_tb.sv */
`timescale 1ns / 1ps

module selective_repeat_sender_window_core_tb;
  import srsw_pkg::*;

  localparam int MAX_PKTS = 65536;
  localparam int HOLD_CYCLES = 400;
  localparam int SETTLE_CYCLES = 20;
  localparam int PHASE_ITEMS = 36;

  // One expected result: kind, sequence number, timer value, last flag
  typedef struct packed {
    kind_e       kind;
    logic [15:0] seq;
    logic [19:0] timer_us;
    logic        last;
  } window_result_t;

  // Sender window predictor plus the queue of results it still owes
  class window_scoreboard;
    bit             acked [MAX_PKTS];
    int unsigned    pkt_count;
    int unsigned    scan_start;
    int unsigned    round_sent;
    int unsigned    round_acks;
    int unsigned    miss_cnt;
    int unsigned    round_timer;
    logic [15:0]    round_seqs[$];
    window_result_t owed_q[$];
    int unsigned    errors;

    function new();
      pkt_count = 1;
      scan_start = 0;
      round_sent = 0;
      round_acks = 0;
      miss_cnt = 0;
      round_timer = TIMER_RESET;
      errors = 0;
    endfunction

    function void set_count(logic [16:0] value);
      pkt_count = (value > MAX_PKTS) ? MAX_PKTS : value;
    endfunction

    function int unsigned pending();
      return owed_q.size();
    endfunction

    function void add_owed(kind_e kind, logic [15:0] seq, logic last);
      window_result_t r;
      r.kind = kind;
      r.seq = seq;
      r.timer_us = round_timer[19:0];
      r.last = last;
      owed_q.push_back(r);
    endfunction

    // Adapt the round timer: grow on heavy loss in a full window, shrink on near-full acks
    function void close_round();
      int unsigned gap;
      if (round_acks < (round_sent * 3) / 4 && round_sent == WIN_EFF) begin
        gap = (round_timer < TIMER_CEIL) ? (TIMER_CEIL - round_timer) : 0;
        round_timer += (gap * 3) / 5;
      end
      if (round_acks + 2 > round_sent)
        round_timer -= round_timer / 100;
      round_timer &= 32'hFFFFF;
      round_sent = 0;
      round_acks = 0;
      add_owed(KIND_CLOSED, 16'd0, 1'b1);
    endfunction

    // Predict the results of one accepted input transfer
    function void note_input(action_e act, logic [15:0] seq);
      int unsigned idx;
      int unsigned n;
      logic [15:0] hits [16];
      if (miss_cnt >= ABORT_MISSES) begin
        add_owed(KIND_ABORT, 16'd0, 1'b1);
        return;
      end
      case (act)
        ACT_START: begin
          round_acks = 0;
          n = 0;
          for (idx = scan_start; idx < pkt_count && n < WIN_EFF; idx++) begin
            if (!acked[idx]) begin
              hits[n] = idx[15:0];
              n++;
            end
          end
          round_seqs.delete();
          if (n == 0) begin
            add_owed(KIND_DONE, 16'd0, 1'b1);
          end else begin
            scan_start = hits[0];
            round_sent = n;
            for (idx = 0; idx < n; idx++) begin
              round_seqs.push_back(hits[idx]);
              add_owed(KIND_SEND, hits[idx], idx + 1 == n);
            end
          end
        end
        ACT_ACK: begin
          if (seq >= pkt_count) begin
            add_owed(KIND_BAD, seq, 1'b1);
          end else begin
            acked[seq] = 1'b1;
            if (round_acks < 31)
              round_acks++;
            miss_cnt = 0;
            add_owed(KIND_ACK, seq, 1'b1);
          end
        end
        ACT_TMO: begin
          miss_cnt++;
          if (miss_cnt >= ABORT_MISSES) begin
            miss_cnt = ABORT_MISSES;
            add_owed(KIND_ABORT, 16'd0, 1'b1);
          end else begin
            close_round();
          end
        end
        default: close_round();
      endcase
    endfunction

    // Compare one result transfer with the oldest expectation
    function void check_result(logic [2:0] kind, logic [15:0] seq, logic [19:0] timer_us,
                               logic last);
      window_result_t want;
      if (owed_q.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected result: kind=%0d seq=%0d timer=%0d last=%0d",
                   kind, seq, timer_us, last);
        return;
      end
      want = owed_q.pop_front();
      if (want.kind != kind || want.seq != seq || want.timer_us != timer_us ||
          want.last != last) begin
        errors++;
        if (errors <= 10) begin
          $display("mismatch: exp kind=%0d seq=%0d timer=%0d last=%0d",
                   want.kind, want.seq, want.timer_us, want.last);
          $display("          got kind=%0d seq=%0d timer=%0d last=%0d",
                   kind, seq, timer_us, last);
        end
      end
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [16:0] cfg_wdata_i;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata;
  logic [1:0]  s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [39:0] m_axis_tdata;
  logic [2:0]  m_axis_tuser;
  logic        m_axis_tlast;

  window_scoreboard sb = new();
  bit          throttle;
  bit          hold_req;
  int unsigned items_sent;

  selective_repeat_sender_window_core #(
    .MAX_PACKETS(MAX_PKTS)
  ) uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Run limit
  initial begin
    #5_000_000;
    $display("FAILED: results differ");
    $finish;
  end

  // Result side: random stalls, plus one long hold-off on request
  initial begin
    int stall;
    m_axis_tready <= 1'b0;
    while (rst_ni !== 1'b1) @(posedge clk_i);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end
      stall = throttle ? $urandom_range(0, 15) : 0;
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!(m_axis_tvalid && m_axis_tready));
    end
  end

  // Check every result transfer
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      sb.check_result(m_axis_tuser, m_axis_tdata[15:0], m_axis_tdata[35:16], m_axis_tlast);
  end

  task automatic write_count(logic [16:0] value);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.set_count(value);
  endtask

  // Offer one item after a random gap when throttled; tvalid stays up if the next gap is zero
  task automatic send_item(action_e act, logic [15:0] seq);
    int gap;
    gap = throttle ? $urandom_range(0, 15) : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= act;
    s_axis_tdata <= seq;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_input(act, seq);
    items_sent++;
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Start a round, ack some of what was sent, then close it or let it time out
  task automatic play_round(int unsigned span);
    int unsigned acks;
    int unsigned k;
    logic [15:0] seq;
    send_item(ACT_START, 16'($urandom));
    acks = $urandom_range(0, 16);
    for (k = 0; k < acks; k++) begin
      if (sb.round_seqs.size() > 0 && $urandom_range(0, 9) < 8)
        seq = sb.round_seqs[$urandom_range(0, sb.round_seqs.size() - 1)];
      else
        seq = 16'($urandom_range(0, span));
      send_item(ACT_ACK, seq);
    end
    if ($urandom_range(0, 2) == 0 && sb.miss_cnt < 2)
      send_item(ACT_TMO, 16'($urandom));
    else
      send_item(ACT_CLOSE, 16'($urandom));
  endtask

  // Any action with random data, never a third timeout in a row
  task automatic send_noise();
    action_e act;
    act = action_e'($urandom_range(0, 3));
    if (act == ACT_TMO && sb.miss_cnt >= 2)
      act = ACT_CLOSE;
    send_item(act, 16'($urandom));
  endtask

  initial begin
    logic [16:0] counts [5];
    int unsigned goal;
    int p;
    counts = '{17'd48, 17'd17, 17'h1FFFF, 17'd300, 17'd1};
    rst_ni <= 1'b0;
    cfg_we_i <= 1'b0;
    cfg_wdata_i <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata <= '0;
    s_axis_tuser <= ACT_START;
    throttle = 1'b0;
    hold_req = 1'b0;
    items_sent = 0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Zero packets: done, bad acks at both ends, close with no round open
    write_count(17'd0);
    send_item(ACT_START, 16'd0);
    send_item(ACT_ACK, 16'd0);
    send_item(ACT_ACK, 16'hFFFF);
    send_item(ACT_CLOSE, 16'd0);
    wait_drained();

    // Small transfer: full window with heavy loss, duplicate ack, edge acks,
    // timeouts that close the round, ack clearing the miss count
    write_count(17'd20);
    send_item(ACT_START, 16'd0);
    send_item(ACT_ACK, 16'd0);
    send_item(ACT_ACK, 16'd5);
    send_item(ACT_CLOSE, 16'd0);
    send_item(ACT_START, 16'd0);
    send_item(ACT_ACK, 16'd1);
    send_item(ACT_ACK, 16'd1);
    send_item(ACT_ACK, 16'd19);
    send_item(ACT_ACK, 16'd20);
    send_item(ACT_TMO, 16'd0);
    send_item(ACT_TMO, 16'd0);
    send_item(ACT_ACK, 16'd2);
    send_item(ACT_START, 16'd0);
    send_item(ACT_CLOSE, 16'd0);
    wait_drained();

    // Random phases over several transfer sizes, the clamped maximum among them
    for (p = 0; p < 5; p++) begin
      write_count(counts[p]);
      throttle = (p != 2);
      if (p == 0)
        hold_req = 1'b1;
      goal = items_sent + PHASE_ITEMS;
      while (items_sent < goal) begin
        if ($urandom_range(0, 9) < 7)
          play_round(sb.pkt_count + 1);
        else
          send_noise();
      end
      wait_drained();
    end

    // Three timeouts in a row abort; everything after answers abort
    throttle = 1'b0;
    send_item(ACT_ACK, 16'd0);
    send_item(ACT_TMO, 16'd0);
    send_item(ACT_TMO, 16'd0);
    send_item(ACT_TMO, 16'd0);
    send_item(ACT_START, 16'd0);
    send_item(ACT_ACK, 16'd0);
    send_item(ACT_CLOSE, 16'd0);
    send_item(ACT_TMO, 16'd0);
    wait_drained();

    if (sb.errors == 0 && sb.pending() == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

endmodule
